// ===== src/pmfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pmfb_pkg: shared constants for the paged monochrome framebuffer blitter
// Display geometry, derived widths, command codes and refresh stream bytes.
// ----------------------------------------------------------------------------
package pmfb_pkg;

	// Display geometry: WIDTH columns by PAGES pages of eight rows each.
	localparam int WIDTH = 128;
	localparam int PAGES = 4;
	localparam int ROWS  = 8 * PAGES;

	// Derived widths.
	localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int COL_W  = $clog2(WIDTH);
	localparam int ROW_W  = $clog2(ROWS + 1);
	localparam int IDX_W  = $clog2(WIDTH + 4);
	localparam int DEPTH  = PAGES * WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);

	// Input stream layout.
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 3;

	// Command codes carried in s_tuser.
	localparam logic [2:0] CMD_FILL   = 3'd0;
	localparam logic [2:0] CMD_BOX    = 3'd1;
	localparam logic [2:0] CMD_BEGIN  = 3'd2;
	localparam logic [2:0] CMD_TEXEL  = 3'd3;
	localparam logic [2:0] CMD_STRIP  = 3'd4;
	localparam logic [2:0] CMD_RENDER = 3'd5;

	// Display command bytes that open each page of the refresh stream.
	localparam logic [7:0] DISP_SET_PAGE = 8'h22;
	localparam logic [7:0] DISP_COL_LO   = 8'h00;
	localparam logic [7:0] DISP_COL_HI   = 8'h10;

endpackage

// ===== src/pmfb_ram.sv =====
// ----------------------------------------------------------------------------
// pmfb_ram: generic single-port RAM
// One address for write or read per cycle; the read data is registered and
// holds until the next read.
// ----------------------------------------------------------------------------
module pmfb_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 512,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Storage array with registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== src/paged_mono_framebuffer_blitter_top.sv =====
// ----------------------------------------------------------------------------
// paged_mono_framebuffer_blitter_top: one-bit framebuffer with page-mode refresh
// The pixels live in a RAM of PAGES*WIDTH column bytes (bit k of a byte is row
// page*8+k), and every box, strip and texel command is carried out by one masked
// read-modify-write unit that walks the clipped rectangle column by column and
// page by page, reading and then writing each touched byte; s_tready is low while it works.
// A drawn texel passes through setup and the read and write of its byte, one that
// lands off screen only through setup, and a transparent or ignored texel leaves
// the sequencer idle. A strip write touches one or two bytes, or none when it misses
// the display. A box touches every byte in its clipped columns and pages, and a
// texture begin or unused command leaves the sequencer idle. A render tick reads
// its byte and then waits only while the previous byte is still not taken on
// the output. Fill, the end of every frame and the release of reset each start a
// sweep that writes all PAGES*WIDTH bytes, during which no command is taken.
// ----------------------------------------------------------------------------
module paged_mono_framebuffer_blitter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// row[8:0], column[17:9], box_height[25:18], box_width[33:26],
	// pixel_value[35:34], mirror[36], strip_byte[44:37], zero fill[47:45]
	input  logic [pmfb_pkg::S_TDATA_W-1:0] s_tdata,
	// command[2:0]
	input  logic [pmfb_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_byte[7:0]
	output logic [7:0]                     m_tdata,
	// is_command[0]
	output logic                           m_tuser,
	// frame_end
	output logic                           m_tlast
);

	localparam int PG_W   = pmfb_pkg::PG_W;
	localparam int COL_W  = pmfb_pkg::COL_W;
	localparam int ROW_W  = pmfb_pkg::ROW_W;
	localparam int IDX_W  = pmfb_pkg::IDX_W;
	localparam int ADDR_W = pmfb_pkg::ADDR_W;

	localparam logic signed [10:0] ROWS_S  = 11'(pmfb_pkg::ROWS);
	localparam logic signed [10:0] WIDTH_S = 11'(pmfb_pkg::WIDTH);

	// Sequencer state codes.
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SETUP = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_WR    = 3'd4;
	localparam logic [2:0] S_RRD   = 3'd5;
	localparam logic [2:0] S_ROUT  = 3'd6;

	// Byte address of a column within a page.
	function automatic logic [ADDR_W-1:0] addr_of(input logic [PG_W-1:0] pg,
			input logic [COL_W-1:0] col);
		addr_of = ADDR_W'(ADDR_W'(pg) * ADDR_W'(pmfb_pkg::WIDTH)) + ADDR_W'(col);
	endfunction

	// Input fields.
	logic [2:0]        in_cmd;
	logic signed [8:0] in_row;
	logic signed [8:0] in_col;
	logic [7:0]        in_h;
	logic [7:0]        in_w;
	logic [1:0]        in_pv;
	logic              in_mir;
	logic [7:0]        in_sb;
	logic              s_xfer;

	// Sequencer and clearing sweep.
	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [7:0]        fill_q;

	// Texture blit state.
	logic signed [8:0] bor_q;
	logic signed [8:0] boc_q;
	logic [7:0]        bh_q;
	logic [7:0]        bw_q;
	logic              bmir_q;
	logic [7:0]        trc_q;
	logic [7:0]        tcc_q;
	logic [7:0]        tex_jj;
	logic              tex_live;

	// Rectangle to draw, before clipping.
	logic signed [9:0] rect_r_q;
	logic signed [9:0] rect_c_q;
	logic [7:0]        rect_h_q;
	logic [7:0]        rect_w_q;
	logic [7:0]        src_q;
	logic [2:0]        rot_q;

	// Clipped rectangle and walk position of the read-modify-write unit.
	logic signed [10:0] r_beg, r_end, r_lo, r_hi;
	logic signed [10:0] c_beg, c_end, c_lo, c_hi;
	logic               rect_empty;
	logic [ROW_W-1:0]   rlo_q;
	logic [ROW_W-1:0]   rhi_q;
	logic [PG_W-1:0]    pg_q;
	logic [PG_W-1:0]    pg_first_q;
	logic [PG_W-1:0]    pg_last_q;
	logic [COL_W-1:0]   col_q;
	logic [COL_W-1:0]   clast_q;
	logic [ROW_W-1:0]   mrow [8];
	logic [7:0]         wmask;
	logic [7:0]         wbits;
	logic [ADDR_W-1:0]  rmw_addr;

	// Refresh stream position and the pending byte.
	logic [IDX_W-1:0]  ridx_q;
	logic [PG_W-1:0]   rpg_q;
	logic [7:0]        ren_byte_q;
	logic              ren_cmd_q;
	logic              ren_fend_q;
	logic [ADDR_W-1:0] ren_addr_q;
	logic              ren_last_idx;
	logic              ren_last_pg;
	logic [7:0]        ren_byte;

	// Output register.
	logic       m_tvalid_q;
	logic [7:0] m_byte_q;
	logic       m_cmd_q;
	logic       m_fend_q;
	logic       out_free;

	// RAM port.
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;

	// Unpack the input transfer.
	assign in_cmd = s_tuser;
	assign in_row = s_tdata[8:0];
	assign in_col = s_tdata[17:9];
	assign in_h   = s_tdata[25:18];
	assign in_w   = s_tdata[33:26];
	assign in_pv  = s_tdata[35:34];
	assign in_mir = s_tdata[36];
	assign in_sb  = s_tdata[44:37];

	assign s_tready = (state_q == S_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Texel column after the optional mirror, and whether the texture is open.
	assign tex_jj   = bmir_q ? (bw_q - 8'd1 - tcc_q) : tcc_q;
	assign tex_live = (bw_q != 8'd0) && (trc_q < bh_q);

	// Clip the rectangle against the display.
	always_comb begin
		r_beg = {rect_r_q[9], rect_r_q};
		r_end = r_beg + $signed({3'b000, rect_h_q});
		c_beg = {rect_c_q[9], rect_c_q};
		c_end = c_beg + $signed({3'b000, rect_w_q});
		r_lo  = r_beg[10] ? 11'sd0 : r_beg;
		r_hi  = (r_end > ROWS_S) ? ROWS_S : r_end;
		c_lo  = c_beg[10] ? 11'sd0 : c_beg;
		c_hi  = (c_end > WIDTH_S) ? WIDTH_S : c_end;
		rect_empty = !(r_lo < r_hi) || !(c_lo < c_hi);
	end

	// Row mask and new pixel bits for the byte at the current page.
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			mrow[k]  = ROW_W'({pg_q, 3'(k)});
			wmask[k] = (mrow[k] >= rlo_q) && (mrow[k] < rhi_q);
			wbits[k] = src_q[3'(3'(k) - rot_q)];
		end
	end

	assign rmw_addr = addr_of(pg_q, col_q);

	// Refresh stream byte for the current position.
	assign ren_last_idx = (ridx_q == IDX_W'(pmfb_pkg::WIDTH + 3));
	assign ren_last_pg  = (rpg_q == PG_W'(pmfb_pkg::PAGES - 1));

	always_comb begin
		case (ridx_q)
			IDX_W'(0): ren_byte = pmfb_pkg::DISP_SET_PAGE;
			IDX_W'(1): ren_byte = 8'(rpg_q);
			IDX_W'(2): ren_byte = pmfb_pkg::DISP_COL_LO;
			IDX_W'(3): ren_byte = pmfb_pkg::DISP_COL_HI;
			default:   ren_byte = 8'h00;
		endcase
	end

	// RAM port selection by sequencer state.
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = rmw_addr;
		ram_wdata = (ram_rdata & ~wmask) | (wbits & wmask);
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = fill_q;
			end
			S_RD: begin
				ram_re = 1'b1;
			end
			S_WR: begin
				ram_we = 1'b1;
			end
			S_RRD: begin
				ram_re   = 1'b1;
				ram_addr = ren_addr_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	pmfb_ram #(
		.DATA_W(8),
		.DEPTH (pmfb_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Sequencer, texture counters, refresh position and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			fill_q     <= 8'h00;
			bor_q      <= '0;
			boc_q      <= '0;
			bh_q       <= 8'd0;
			bw_q       <= 8'd0;
			bmir_q     <= 1'b0;
			trc_q      <= 8'd0;
			tcc_q      <= 8'd0;
			ridx_q     <= '0;
			rpg_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// The output register fills from a finished render tick, else drains.
			if (state_q == S_ROUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (clr_q == ADDR_W'(pmfb_pkg::DEPTH - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + ADDR_W'(1);
					end
				end
				S_IDLE: begin
					if (s_xfer) begin
						case (in_cmd)
							pmfb_pkg::CMD_FILL: begin
								fill_q  <= {8{in_pv[0]}};
								state_q <= S_CLEAR;
							end
							pmfb_pkg::CMD_BOX, pmfb_pkg::CMD_STRIP: begin
								state_q <= S_SETUP;
							end
							pmfb_pkg::CMD_BEGIN: begin
								bor_q  <= in_row;
								boc_q  <= in_col;
								bh_q   <= in_h;
								bw_q   <= in_w;
								bmir_q <= in_mir;
								trc_q  <= 8'd0;
								tcc_q  <= 8'd0;
							end
							pmfb_pkg::CMD_TEXEL: begin
								if (tex_live) begin
									if (tcc_q + 8'd1 >= bw_q) begin
										tcc_q <= 8'd0;
										trc_q <= trc_q + 8'd1;
									end else begin
										tcc_q <= tcc_q + 8'd1;
									end
									if (!in_pv[1]) begin
										state_q <= S_SETUP;
									end
								end
							end
							pmfb_pkg::CMD_RENDER: begin
								if (ren_last_idx) begin
									ridx_q <= '0;
									rpg_q  <= ren_last_pg ? '0 : rpg_q + PG_W'(1);
								end else begin
									ridx_q <= ridx_q + IDX_W'(1);
								end
								state_q <= S_RRD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SETUP: begin
					state_q <= rect_empty ? S_IDLE : S_RD;
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (pg_q == pg_last_q && col_q == clast_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RRD: begin
					state_q <= S_ROUT;
				end
				S_ROUT: begin
					if (out_free) begin
						if (ren_fend_q) begin
							fill_q  <= 8'h00;
							state_q <= S_CLEAR;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: rectangle, walk position, pending and output bytes.
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			case (in_cmd)
				pmfb_pkg::CMD_BOX: begin
					rect_r_q <= {in_row[8], in_row};
					rect_c_q <= {in_col[8], in_col};
					rect_h_q <= in_h;
					rect_w_q <= in_w;
					src_q    <= {8{in_pv[0]}};
					rot_q    <= 3'd0;
				end
				pmfb_pkg::CMD_STRIP: begin
					rect_r_q <= {in_row[8], in_row};
					rect_c_q <= {in_col[8], in_col};
					rect_h_q <= 8'd8;
					rect_w_q <= 8'd1;
					src_q    <= in_sb;
					rot_q    <= in_row[2:0];
				end
				pmfb_pkg::CMD_TEXEL: begin
					rect_r_q <= {bor_q[8], bor_q} + $signed({2'b00, trc_q});
					rect_c_q <= {boc_q[8], boc_q} + $signed({2'b00, tex_jj});
					rect_h_q <= 8'd1;
					rect_w_q <= 8'd1;
					src_q    <= {8{in_pv[0]}};
					rot_q    <= 3'd0;
				end
				pmfb_pkg::CMD_RENDER: begin
					ren_byte_q <= ren_byte;
					ren_cmd_q  <= (ridx_q < IDX_W'(4));
					ren_fend_q <= ren_last_idx && ren_last_pg;
					ren_addr_q <= addr_of(rpg_q, COL_W'(ridx_q - IDX_W'(4)));
				end
				default: begin
					rot_q <= rot_q;
				end
			endcase
		end
		// Load the walk limits from the clipped rectangle.
		if (state_q == S_SETUP) begin
			rlo_q      <= ROW_W'(r_lo);
			rhi_q      <= ROW_W'(r_hi);
			pg_q       <= PG_W'(ROW_W'(r_lo) >> 3);
			pg_first_q <= PG_W'(ROW_W'(r_lo) >> 3);
			pg_last_q  <= PG_W'(ROW_W'(r_hi - 11'sd1) >> 3);
			col_q      <= COL_W'(c_lo);
			clast_q    <= COL_W'(c_hi - 11'sd1);
		end
		// Step down the pages of a column, then to the next column.
		if (state_q == S_WR) begin
			if (pg_q != pg_last_q) begin
				pg_q <= pg_q + PG_W'(1);
			end else begin
				pg_q  <= pg_first_q;
				col_q <= col_q + COL_W'(1);
			end
		end
		// Hand the pending refresh byte to the output register.
		if (state_q == S_ROUT && out_free) begin
			m_byte_q <= ren_cmd_q ? ren_byte_q : ram_rdata;
			m_cmd_q  <= ren_cmd_q;
			m_fend_q <= ren_fend_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_byte_q;
	assign m_tuser  = m_cmd_q;
	assign m_tlast  = m_fend_q;

`ifndef SYNTH
	// A read of the modify unit is always followed by its write.
	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |=> (state_q == S_WR))
		else $error("read-modify-write read not followed by write");

	// The page walk stays within the clipped page range.
	a_pg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> (pg_q >= pg_first_q && pg_q <= pg_last_q))
		else $error("page walk left the clipped range");

	// The refresh position never passes the last byte of a page.
	a_ridx_range: assert property (@(posedge clk) disable iff (!arst_n)
		ridx_q <= IDX_W'(pmfb_pkg::WIDTH + 3))
		else $error("refresh index out of range");

	// A frame ends on a data byte, never on a command byte.
	a_fend_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !m_tuser)
		else $error("frame end marked on a command byte");

	// A render byte waiting for a free output slot is delivered next cycle.
	a_rout_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUT && !m_tvalid_q) |=> m_tvalid_q)
		else $error("refresh byte not loaded into a free output register");
`endif

endmodule
